### rtl/lbvs_pkg.sv
// Shared constants and types for the linear blend vertex skinning block.
// No dependencies; every other file refers to it by scoped names.
`default_nettype none
package lbvs_pkg;
	localparam int MAX_BONES  = 64;
	localparam int FRAC_BITS  = 16;
	localparam int INFLUENCES = 4;
	localparam int WORDS      = 12;
	localparam int WEIGHT_FRAC = 15;
	localparam int BONE_W     = (MAX_BONES > 1) ? $clog2(MAX_BONES) : 1;

	localparam int WORD_W = 32;
	localparam int PROD_W = 2 * WORD_W;
	localparam int T_W    = PROD_W + 3;
	localparam int TC_W   = 48;
	localparam int CP_W   = TC_W + 17;
	localparam int ACC_W  = CP_W + 2;

	localparam int IN_DATA_W  = 240;
	localparam int OUT_DATA_W = 96;

	typedef enum logic {
		FUNC_PAL_WRITE = 1'b0,
		FUNC_SKIN      = 1'b1
	} func_t;

	typedef logic signed [WORD_W-1:0] word_t;
	typedef logic [BONE_W-1:0] bone_addr_t;
endpackage
`default_nettype wire

### rtl/linear_blend_vertex_skinning.sv
// Top level of the linear blend vertex skinning pipeline.
// Depends on lbvs_pkg and lbvs_palette.
//
//  channel   direction  beat contents
//  s_axis    in         palette word write (tuser=0) or vertex (tuser=1)
//  m_axis    out        one skinned position per vertex beat
//
// One beat is accepted every cycle unless the pipeline stalls. Stage 1 loads at
// the accept edge, and a vertex result is presented on m_axis from the stage 7
// output register. The seven register stages are palette read, products,
// column sum, clamp, weight product, blend sum and output.
// Palette writes take effect at their accept edge and give no result.
// Reset clears only the stage valid bits; the palette is undefined until written.
// Each stage holds while the stage after it is full and stalled, so bubbles
// are squeezed out and a stall drops or repeats nothing.
`default_nettype none
module linear_blend_vertex_skinning (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	// tdata: pos_x, pos_y, pos_z, bone_indices, blend_weights, pal_bone,
	// pal_word, pal_value, then zero padding
	input  wire logic [lbvs_pkg::IN_DATA_W-1:0] s_axis_tdata,
	input  wire logic        s_axis_tuser,   // func
	input  wire logic        s_axis_tlast,   // last_in
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [lbvs_pkg::OUT_DATA_W-1:0] m_axis_tdata, // skin_x, skin_y, skin_z
	output logic [1:0]       m_axis_tuser,   // index_fault, saturated
	output logic             m_axis_tlast    // last_out
);
	localparam int N = lbvs_pkg::INFLUENCES;
	localparam int W = lbvs_pkg::WORD_W;

	// Input field extraction.
	lbvs_pkg::word_t pos_in [3];
	logic [31:0] bone_indices;
	logic [63:0] blend_weights;
	logic [5:0]  pal_bone;
	logic [3:0]  pal_word;
	lbvs_pkg::word_t pal_value;

	assign pos_in[0]     = s_axis_tdata[31:0];
	assign pos_in[1]     = s_axis_tdata[63:32];
	assign pos_in[2]     = s_axis_tdata[95:64];
	assign bone_indices  = s_axis_tdata[127:96];
	assign blend_weights = s_axis_tdata[191:128];
	assign pal_bone      = s_axis_tdata[197:192];
	assign pal_word      = s_axis_tdata[201:198];
	assign pal_value     = s_axis_tdata[233:202];

	// Stage valid bits and the enables that let each stage load.
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic en1, en2, en3, en4, en5, en6, en7;

	assign en7 = !v_s7 || m_axis_tready;
	assign en6 = !v_s6 || en7;
	assign en5 = !v_s5 || en6;
	assign en4 = !v_s4 || en5;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign s_axis_tready = en1;

	logic acc_in, is_skin, pal_we;
	assign acc_in  = s_axis_tvalid && s_axis_tready;
	assign is_skin = (s_axis_tuser == lbvs_pkg::FUNC_SKIN);
	assign pal_we  = acc_in && !is_skin && int'(pal_bone) < lbvs_pkg::MAX_BONES
	                 && int'(pal_word) < lbvs_pkg::WORDS;

	// Bone indices: an index outside the palette faults and its influence drops out.
	lbvs_pkg::bone_addr_t raddr [N];
	logic [N-1:0] idx_ok;
	always_comb begin
		for (int k = 0; k < N; k++) begin
			raddr[k]  = bone_indices[8*k +: lbvs_pkg::BONE_W];
			idx_ok[k] = int'(bone_indices[8*k +: 8]) < lbvs_pkg::MAX_BONES;
		end
	end

	// Stage 1: palette read plus the vertex fields.
	lbvs_pkg::word_t mat_s1 [N][lbvs_pkg::WORDS];
	lbvs_pkg::word_t pos_s1 [3];
	logic [15:0]  wt_s1 [N];
	logic [N-1:0] ok_s1;
	logic         last_s1;

	lbvs_palette u_palette (
		.clk   (clk),
		.we    (pal_we),
		.waddr (lbvs_pkg::BONE_W'(pal_bone)),
		.wword (pal_word),
		.wdata (pal_value),
		.ren   (en1),
		.raddr (raddr),
		.rd_s1 (mat_s1)
	);

	always_ff @(posedge clk) begin
		if (en1) begin
			pos_s1  <= pos_in;
			ok_s1   <= idx_ok;
			last_s1 <= s_axis_tlast;
			for (int k = 0; k < N; k++) begin
				wt_s1[k] <= blend_weights[16*k +: 16];
			end
		end
	end

	// Stage 2: the nine exact products per influence.
	logic signed [lbvs_pkg::PROD_W-1:0] prod_s2 [N][3][3];
	lbvs_pkg::word_t off_s2 [N][3];
	logic [15:0]  wt_s2 [N];
	logic [N-1:0] ok_s2;
	logic         last_s2;

	always_ff @(posedge clk) begin
		if (en2) begin
			for (int k = 0; k < N; k++) begin
				for (int c = 0; c < 3; c++) begin
					for (int r = 0; r < 3; r++) begin
						prod_s2[k][c][r] <= lbvs_pkg::PROD_W'(pos_s1[r])
						                    * lbvs_pkg::PROD_W'(mat_s1[k][3*r + c]);
					end
					off_s2[k][c] <= mat_s1[k][9 + c];
				end
			end
			wt_s2   <= wt_s1;
			ok_s2   <= ok_s1;
			last_s2 <= last_s1;
		end
	end

	// Stage 3: column sum, floor shift to the integer scale, translation.
	logic signed [lbvs_pkg::T_W-1:0] t_s3 [N][3];
	logic [15:0]  wt_s3 [N];
	logic [N-1:0] ok_s3;
	logic         last_s3;

	always_ff @(posedge clk) begin
		if (en3) begin
			for (int k = 0; k < N; k++) begin
				for (int c = 0; c < 3; c++) begin
					t_s3[k][c] <= ((lbvs_pkg::T_W'(prod_s2[k][c][0])
					              + lbvs_pkg::T_W'(prod_s2[k][c][1])
					              + lbvs_pkg::T_W'(prod_s2[k][c][2])) >>> lbvs_pkg::FRAC_BITS)
					              + lbvs_pkg::T_W'(off_s2[k][c]);
				end
			end
			wt_s3   <= wt_s2;
			ok_s3   <= ok_s2;
			last_s3 <= last_s2;
		end
	end

	// Stage 4: clamp each transformed coordinate to 48 bits.
	localparam logic signed [lbvs_pkg::T_W-1:0] TC_MAX =
		lbvs_pkg::T_W'({1'b0, {(lbvs_pkg::TC_W-1){1'b1}}});
	localparam logic signed [lbvs_pkg::T_W-1:0] TC_MIN = -TC_MAX - 1;

	logic signed [lbvs_pkg::TC_W-1:0] tc_s4 [N][3];
	logic [15:0]  wt_s4 [N];
	logic [N-1:0] ok_s4;
	logic         sat_s4, last_s4;
	logic signed [lbvs_pkg::TC_W-1:0] tc_d [N][3];
	logic         sat_d;

	always_comb begin
		sat_d = 1'b0;
		for (int k = 0; k < N; k++) begin
			for (int c = 0; c < 3; c++) begin
				if (t_s3[k][c] > TC_MAX) begin
					tc_d[k][c] = TC_MAX[lbvs_pkg::TC_W-1:0];
					sat_d = sat_d | ok_s3[k];
				end else if (t_s3[k][c] < TC_MIN) begin
					tc_d[k][c] = TC_MIN[lbvs_pkg::TC_W-1:0];
					sat_d = sat_d | ok_s3[k];
				end else begin
					tc_d[k][c] = t_s3[k][c][lbvs_pkg::TC_W-1:0];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en4) begin
			tc_s4   <= tc_d;
			sat_s4  <= sat_d;
			wt_s4   <= wt_s3;
			ok_s4   <= ok_s3;
			last_s4 <= last_s3;
		end
	end

	// Stage 5: weight products.
	logic signed [lbvs_pkg::CP_W-1:0] cp_s5 [N][3];
	logic [N-1:0] ok_s5;
	logic         sat_s5, last_s5;

	always_ff @(posedge clk) begin
		if (en5) begin
			for (int k = 0; k < N; k++) begin
				for (int c = 0; c < 3; c++) begin
					cp_s5[k][c] <= lbvs_pkg::CP_W'(tc_s4[k][c])
					               * lbvs_pkg::CP_W'(signed'({1'b0, wt_s4[k]}));
				end
			end
			ok_s5   <= ok_s4;
			sat_s5  <= sat_s4;
			last_s5 <= last_s4;
		end
	end

	// Stage 6: scale down and blend the valid influences.
	logic signed [lbvs_pkg::ACC_W-1:0] acc_s6 [3];
	logic         fault_s6, sat_s6, last_s6;
	logic signed [lbvs_pkg::ACC_W-1:0] acc_d [3];

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			acc_d[c] = '0;
			for (int k = 0; k < N; k++) begin
				if (ok_s5[k]) begin
					acc_d[c] = acc_d[c]
					           + lbvs_pkg::ACC_W'(cp_s5[k][c] >>> lbvs_pkg::WEIGHT_FRAC);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en6) begin
			acc_s6   <= acc_d;
			fault_s6 <= !(&ok_s5);
			sat_s6   <= sat_s5;
			last_s6  <= last_s5;
		end
	end

	// Stage 7: clamp to 32 bits into the output register.
	localparam logic signed [lbvs_pkg::ACC_W-1:0] OUT_MAX =
		lbvs_pkg::ACC_W'({1'b0, {(W-1){1'b1}}});
	localparam logic signed [lbvs_pkg::ACC_W-1:0] OUT_MIN = -OUT_MAX - 1;

	lbvs_pkg::word_t skin_d [3];
	logic            sat7_d;

	always_comb begin
		sat7_d = sat_s6;
		for (int c = 0; c < 3; c++) begin
			if (acc_s6[c] > OUT_MAX) begin
				skin_d[c] = OUT_MAX[W-1:0];
				sat7_d = 1'b1;
			end else if (acc_s6[c] < OUT_MIN) begin
				skin_d[c] = OUT_MIN[W-1:0];
				sat7_d = 1'b1;
			end else begin
				skin_d[c] = acc_s6[c][W-1:0];
			end
		end
	end

	lbvs_pkg::word_t skin_s7 [3];
	logic fault_s7, sat_s7, last_s7;

	always_ff @(posedge clk) begin
		if (en7) begin
			skin_s7  <= skin_d;
			fault_s7 <= fault_s6;
			sat_s7   <= sat7_d;
			last_s7  <= last_s6;
		end
	end

	// Valid bits; palette writes never enter the pipeline.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			if (en1) v_s1 <= acc_in && is_skin;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
			if (en5) v_s5 <= v_s4;
			if (en6) v_s6 <= v_s5;
			if (en7) v_s7 <= v_s6;
		end
	end

	assign m_axis_tvalid = v_s7;
	assign m_axis_tdata  = {skin_s7[2], skin_s7[1], skin_s7[0]};
	assign m_axis_tuser  = {sat_s7, fault_s7};
	assign m_axis_tlast  = last_s7;

	// A vertex beat always lands in stage 1.
	a_vertex_enters: assert property (@(posedge clk) disable iff (!arst_n)
		acc_in && is_skin |=> v_s1)
		else $error("accepted vertex missing from stage 1");

	// A palette write never creates a pipeline item.
	a_write_no_item: assert property (@(posedge clk) disable iff (!arst_n)
		acc_in && !is_skin |=> !v_s1)
		else $error("palette write produced a pipeline item");

	// While the output is held back no item can leave, so none may vanish.
	a_no_loss: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tready |=> $countones({v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7})
		>= $past($countones({v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7})))
		else $error("pipeline item lost during output stall");
endmodule
`default_nettype wire

### rtl/lbvs_palette.sv
// Bone matrix palette: a bank per matrix word and influence, each read at
// one address a cycle while ren is high, registered. Depends on lbvs_pkg.
`default_nettype none
module lbvs_palette (
	input  wire logic                clk,
	input  wire logic                we,
	input  wire lbvs_pkg::bone_addr_t waddr,
	input  wire logic [3:0]          wword,
	input  wire lbvs_pkg::word_t     wdata,
	input  wire logic                ren,
	input  wire lbvs_pkg::bone_addr_t raddr [lbvs_pkg::INFLUENCES],
	output lbvs_pkg::word_t          rd_s1 [lbvs_pkg::INFLUENCES][lbvs_pkg::WORDS]
);
	// Every influence owns a full copy so that four bones are read at once.
	for (genvar k = 0; k < lbvs_pkg::INFLUENCES; k++) begin : g_infl
		for (genvar w = 0; w < lbvs_pkg::WORDS; w++) begin : g_word
			lbvs_pkg::word_t bank [lbvs_pkg::MAX_BONES];
			always_ff @(posedge clk) begin
				if (we && int'(wword) == w) begin
					bank[waddr] <= wdata;
				end
				if (ren) begin
					rd_s1[k][w] <= bank[raddr[k]];
				end
			end
		end
	end
endmodule
`default_nettype wire

### tb/tb_top.sv
// Self-checking testbench for the linear blend vertex skinning block.
// Needs lbvs_pkg and linear_blend_vertex_skinning.
// It loads the bone palette, then runs a directed table and a random vertex stream.
`timescale 1ns / 1ps
module tb_top;
	// One input beat, split into its fields.
	typedef struct {
		lbvs_pkg::func_t func;
		logic [31:0] px, py, pz;
		logic [31:0] idx;
		logic [63:0] wts;
		logic [5:0]  bone;
		logic [3:0]  word;
		logic [31:0] val;
		logic        last;
	} beat_t;

	// One skinned vertex, split into its fields.
	typedef struct {
		logic [31:0] x, y, z;
		logic        fault, sat, last;
	} skinned_t;

	// A directed row carries its expected vertex when that can be read off directly.
	typedef struct {
		beat_t    b;
		bit       typed;
		skinned_t r;
	} row_t;

	// Only the lower bones are preloaded and used by vertices; this keeps the run short.
	localparam int USED_BONES   = 16;
	localparam int VERTEX_COUNT = 380;
	localparam int QUIET_TAIL   = 60;
	localparam int CYCLE_LIMIT  = 300000;

	logic clk, arst_n;
	logic s_axis_tvalid, s_axis_tready, s_axis_tuser, s_axis_tlast;
	logic [lbvs_pkg::IN_DATA_W-1:0] s_axis_tdata;
	logic m_axis_tvalid, m_axis_tready, m_axis_tlast;
	logic [lbvs_pkg::OUT_DATA_W-1:0] m_axis_tdata;
	logic [1:0] m_axis_tuser;

	linear_blend_vertex_skinning uut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast)
	);

	// Shadow copy of the bone palette, updated as write beats are accepted.
	logic signed [31:0] bone_mats [lbvs_pkg::MAX_BONES][lbvs_pkg::WORDS];
	skinned_t pending_vertices[$];
	int  errors = 0;
	bit  quiet = 1'b0;
	int  cycles = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Skins one vertex against the shadow palette: per influence an affine
	// transform with floor rounding, a 48-bit clamp, a Q1.15 weight, then a
	// 32-bit clamp on the blended sum.
	function automatic skinned_t skin_vertex(beat_t b);
		skinned_t r;
		logic signed [67:0] pos [3];
		logic signed [67:0] acc [3];
		logic signed [67:0] t, wt;
		logic [7:0] bi;
		logic [31:0] res [3];
		r.fault = 1'b0;
		r.sat = 1'b0;
		pos[0] = 68'($signed(b.px));
		pos[1] = 68'($signed(b.py));
		pos[2] = 68'($signed(b.pz));
		for (int c = 0; c < 3; c++) acc[c] = '0;
		for (int k = 0; k < lbvs_pkg::INFLUENCES; k++) begin
			bi = b.idx[8*k +: 8];
			wt = {52'd0, b.wts[16*k +: 16]};
			if (bi >= lbvs_pkg::MAX_BONES) begin
				r.fault = 1'b1;
				continue;
			end
			for (int c = 0; c < 3; c++) begin
				t = '0;
				for (int row = 0; row < 3; row++)
					t += pos[row]
					     * 68'(bone_mats[bi[lbvs_pkg::BONE_W-1:0]][3*row + c]);
				t = (t >>> lbvs_pkg::FRAC_BITS)
				    + 68'(bone_mats[bi[lbvs_pkg::BONE_W-1:0]][9 + c]);
				if (t > 68'sh7FFF_FFFF_FFFF) begin
					t = 68'sh7FFF_FFFF_FFFF;
					r.sat = 1'b1;
				end
				if (t < -68'sh8000_0000_0000) begin
					t = -68'sh8000_0000_0000;
					r.sat = 1'b1;
				end
				acc[c] += (t * wt) >>> lbvs_pkg::WEIGHT_FRAC;
			end
		end
		for (int c = 0; c < 3; c++) begin
			if (acc[c] > 68'sh7FFF_FFFF) begin
				acc[c] = 68'sh7FFF_FFFF;
				r.sat = 1'b1;
			end
			if (acc[c] < -68'sh8000_0000) begin
				acc[c] = -68'sh8000_0000;
				r.sat = 1'b1;
			end
			res[c] = acc[c][31:0];
		end
		r.x = res[0];
		r.y = res[1];
		r.z = res[2];
		r.last = b.last;
		return r;
	endfunction

	// Mostly small matrix words so results stay in range, with some extremes.
	function automatic logic [31:0] rand_mat_word();
		case ($urandom_range(0, 9))
			0: return $urandom;
			1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
			default: return 32'($urandom_range(0, 262143)) - 32'd131072;
		endcase
	endfunction

	function automatic logic [31:0] rand_coord();
		if ($urandom_range(0, 7) == 0) return $urandom;
		return 32'($urandom_range(0, 33554431)) - 32'd16777216;
	endfunction

	function automatic beat_t pal_beat(int bone, int word, logic [31:0] val);
		beat_t b;
		b.func = lbvs_pkg::FUNC_PAL_WRITE;
		b.px = $urandom;
		b.py = $urandom;
		b.pz = $urandom;
		b.idx = $urandom;
		b.wts = {$urandom, $urandom};
		b.bone = 6'(bone);
		b.word = 4'(word);
		b.val = val;
		b.last = 1'($urandom_range(0, 1));
		return b;
	endfunction

	function automatic beat_t vertex_beat(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
			logic [31:0] idx, logic [63:0] wts, logic last);
		beat_t b;
		b.func = lbvs_pkg::FUNC_SKIN;
		b.px = px;
		b.py = py;
		b.pz = pz;
		b.idx = idx;
		b.wts = wts;
		b.bone = 6'($urandom);
		b.word = 4'($urandom);
		b.val = $urandom;
		b.last = last;
		return b;
	endfunction

	function automatic skinned_t known(logic [31:0] x, logic [31:0] y, logic [31:0] z,
			logic fault, logic sat, logic last);
		skinned_t r;
		r.x = x;
		r.y = y;
		r.z = z;
		r.fault = fault;
		r.sat = sat;
		r.last = last;
		return r;
	endfunction

	// Drives one beat, waits for its handshake and then updates the shadow
	// palette or queues the expected vertex. An idle burst may come first.
	task automatic send_beat(beat_t b, bit typed, skinned_t r);
		int gap;
		if (!quiet && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 13);
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= b.func;
		s_axis_tlast <= b.last;
		s_axis_tdata <= {6'd0, b.val, b.word, b.bone, b.wts, b.idx, b.pz, b.py, b.px};
		do @(posedge clk); while (!s_axis_tready);
		if (b.func == lbvs_pkg::FUNC_PAL_WRITE) begin
			if (b.word < lbvs_pkg::WORDS) bone_mats[b.bone][b.word] = b.val;
		end else begin
			pending_vertices = {pending_vertices, typed ? r : skin_vertex(b)};
		end
	endtask

	// Output side: random stall bursts, and each vertex beat checked in order.
	int stall_left = 0;
	always @(posedge clk) begin
		skinned_t e;
		if (m_axis_tvalid && m_axis_tready) begin
			if (pending_vertices.size() == 0) begin
				$error("vertex beat with nothing expected");
				errors++;
			end else begin
				e = pending_vertices.pop_front();
				if (m_axis_tdata[31:0] !== e.x) begin
					$error("skin_x expected %h got %h", e.x, m_axis_tdata[31:0]);
					errors++;
				end
				if (m_axis_tdata[63:32] !== e.y) begin
					$error("skin_y expected %h got %h", e.y, m_axis_tdata[63:32]);
					errors++;
				end
				if (m_axis_tdata[95:64] !== e.z) begin
					$error("skin_z expected %h got %h", e.z, m_axis_tdata[95:64]);
					errors++;
				end
				if (m_axis_tuser[0] !== e.fault) begin
					$error("index_fault expected %b got %b", e.fault, m_axis_tuser[0]);
					errors++;
				end
				if (m_axis_tuser[1] !== e.sat) begin
					$error("saturated expected %b got %b", e.sat, m_axis_tuser[1]);
					errors++;
				end
				if (m_axis_tlast !== e.last) begin
					$error("last_out expected %b got %b", e.last, m_axis_tlast);
					errors++;
				end
			end
		end
		if (!arst_n || quiet) begin
			m_axis_tready <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			m_axis_tready <= (stall_left == 1);
		end else if ($urandom_range(0, 5) == 0) begin
			stall_left <= $urandom_range(1, 13);
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		row_t rows[$];
		row_t row;
		skinned_t none;
		beat_t b;
		int vertices;
		logic [31:0] idx;
		logic [63:0] wts;

		none = known(32'h0, 32'h0, 32'h0, 1'b0, 1'b0, 1'b0);
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tuser = 1'b0;
		s_axis_tlast = 1'b0;
		s_axis_tdata = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Fill every word of the used bones before any vertex reads it. Bone 0
		// is the identity and bone 2 holds the largest word everywhere.
		for (int bn = 0; bn < USED_BONES; bn++)
			for (int w = 0; w < lbvs_pkg::WORDS; w++) begin
				if (bn == 0) send_beat(pal_beat(bn, w,
						(w == 0 || w == 4 || w == 8) ? 32'h0001_0000 : 32'h0), 1'b0, none);
				else if (bn == 2) send_beat(pal_beat(bn, w, 32'h7FFF_FFFF), 1'b0, none);
				else send_beat(pal_beat(bn, w, rand_mat_word()), 1'b0, none);
			end

		// Directed table: ignored palette writes, zero weights, all indices
		// out of range, identity bone, both saturation directions, mixed faults,
		// and a translation written just before the vertex that uses it.
		row.typed = 1'b0;
		row.r = none;
		row.b = pal_beat(5, 12, 32'h1234_5678);
		rows = {rows, row};
		row.b = pal_beat(63, 15, 32'hFFFF_FFFF);
		rows = {rows, row};
		row.typed = 1'b1;
		row.b = vertex_beat(32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000, 32'h0, 64'h0, 1'b1);
		row.r = known(32'h0, 32'h0, 32'h0, 1'b0, 1'b0, 1'b1);
		rows = {rows, row};
		row.b = vertex_beat(32'h1, 32'h2, 32'h3, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
				1'b0);
		row.r = known(32'h0, 32'h0, 32'h0, 1'b1, 1'b0, 1'b0);
		rows = {rows, row};
		row.b = vertex_beat(32'h0001_0000, 32'h0002_0000, 32'hFFFD_0000, 32'h0,
				64'h0000_0000_0000_8000, 1'b1);
		row.r = known(32'h0001_0000, 32'h0002_0000, 32'hFFFD_0000, 1'b0, 1'b0, 1'b1);
		rows = {rows, row};
		row.b = vertex_beat(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0202_0202,
				64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
		row.r = known(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 1'b1, 1'b0);
		rows = {rows, row};
		row.b = vertex_beat(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h0202_0202,
				64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
		row.r = known(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0, 1'b1, 1'b1);
		rows = {rows, row};
		row.b = pal_beat(0, 9, 32'h0001_0000);
		row.typed = 1'b0;
		row.r = none;
		rows = {rows, row};
		row.typed = 1'b1;
		row.b = vertex_beat(32'h0, 32'h0, 32'h0, 32'h0, 64'h0000_0000_0000_8000, 1'b0);
		row.r = known(32'h0001_0000, 32'h0, 32'h0, 1'b0, 1'b0, 1'b0);
		rows = {rows, row};
		row.typed = 1'b0;
		row.r = none;
		row.b = vertex_beat(rand_coord(), rand_coord(), rand_coord(), 32'h40FF_0300,
				{$urandom, $urandom}, 1'b1);
		rows = {rows, row};
		for (int i = 0; i < 6; i++) begin
			row.b = vertex_beat(rand_coord(), rand_coord(), rand_coord(),
					{4'b0000, 4'($urandom), 4'b0000, 4'($urandom), 4'b0000, 4'($urandom),
					4'b0000, 4'($urandom)}, {$urandom, $urandom},
					1'($urandom_range(0, 1)));
			rows = {rows, row};
		end
		foreach (rows[i]) send_beat(rows[i].b, rows[i].typed, rows[i].r);

		// Random stream: mostly vertices, some palette rewrites mixed in.
		vertices = 0;
		while (vertices < VERTEX_COUNT) begin
			quiet = (vertices >= VERTEX_COUNT - QUIET_TAIL);
			if ($urandom_range(0, 6) == 0) begin
				send_beat(pal_beat($urandom_range(0, 63), $urandom_range(0, 15),
						rand_mat_word()), 1'b0, none);
			end else begin
				for (int k = 0; k < 4; k++) begin
					idx[8*k +: 8] = ($urandom_range(0, 19) == 0) ?
							8'($urandom_range(64, 255)) :
							8'($urandom_range(0, USED_BONES - 1));
					wts[16*k +: 16] = ($urandom_range(0, 3) == 0) ?
							16'($urandom) : 16'($urandom_range(0, 16'h8000));
				end
				b = vertex_beat(rand_coord(), rand_coord(), rand_coord(), idx, wts,
						1'($urandom_range(0, 1)));
				send_beat(b, 1'b0, none);
				vertices++;
			end
		end
		s_axis_tvalid <= 1'b0;

		while (pending_vertices.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (errors == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end
endmodule

### filelist.f
rtl/lbvs_pkg.sv
rtl/lbvs_palette.sv
rtl/linear_blend_vertex_skinning.sv
tb/tb_top.sv
